// ===== hdl/slkt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slkt_pkg
// Shared constants, codes and controller/datapath interface types for the
// sorted leaf key table.
// ----------------------------------------------------------------------------
package slkt_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 64;

    localparam int OP_W   = 2;
    localparam int KEY_W  = 32;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 64;
    localparam int IDX_W  = 5;
    localparam int CNT_W  = 5;
    localparam int STAT_W = 2;

    // input request layout
    localparam int IN_OP_LSB  = 0;
    localparam int IN_KEY_LSB = IN_OP_LSB + OP_W;
    localparam int IN_POS_LSB = IN_KEY_LSB + KEY_W;
    localparam int IN_VAL_LSB = IN_POS_LSB + POS_W;
    localparam int IN_USED_W  = IN_VAL_LSB + VAL_W;
    localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

    // result layout
    localparam int OUT_IDX_LSB  = 0;
    localparam int OUT_HIT_LSB  = OUT_IDX_LSB + IDX_W;
    localparam int OUT_VAL_LSB  = OUT_HIT_LSB + 1;
    localparam int OUT_CNT_LSB  = OUT_VAL_LSB + VAL_W;
    localparam int OUT_STAT_LSB = OUT_CNT_LSB + CNT_W;
    localparam int OUT_USED_W   = OUT_STAT_LSB + STAT_W;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic load;
        logic probe;
        logic step;
        logic shift_rd;
        logic shift_wr;
        logic ins_wr;
        logic upd_wr;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic is_find;
        logic is_insert;
        logic is_update;
        logic status_ok;
        logic lo_eq_hi;
        logic key_eq;
        logic ptr_gt_pos;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/slkt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slkt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module slkt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/slkt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slkt_ctrl
// Sequencer for find, insert and update requests: binary search probes,
// cell shifting for insert and result hand-off.
// ----------------------------------------------------------------------------
module slkt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  slkt_pkg::t_sts i_sts,
    output slkt_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH_CHK,
        S_SRCH_CMP,
        S_SH_CHK,
        S_SH_WR,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_sts.is_find) begin
                    n_state = S_SRCH_CHK;
                end else if (i_sts.is_insert && i_sts.status_ok) begin
                    n_state = S_SH_CHK;
                end else if (i_sts.is_update && i_sts.status_ok) begin
                    o_cmd.upd_wr = 1'b1;
                    n_state      = S_RESP;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SRCH_CHK: begin
                if (i_sts.lo_eq_hi) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = i_sts.key_eq ? S_RESP : S_SRCH_CHK;
            end
            S_SH_CHK: begin
                if (i_sts.ptr_gt_pos) begin
                    o_cmd.shift_rd = 1'b1;
                    n_state        = S_SH_WR;
                end else begin
                    o_cmd.ins_wr = 1'b1;
                    n_state      = S_RESP;
                end
            end
            S_SH_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = S_SH_CHK;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== hdl/slkt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slkt_datapath
// Key and value cell memories, search bounds, shift pointer, cell count
// and the result register.
// ----------------------------------------------------------------------------
module slkt_datapath #(
    parameter int VALUE_BITS = slkt_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  slkt_pkg::t_cmd               i_cmd,
    output slkt_pkg::t_sts               o_sts,
    input  logic [slkt_pkg::OP_W-1:0]    i_op,
    input  logic [slkt_pkg::KEY_W-1:0]   i_key,
    input  logic [slkt_pkg::POS_W-1:0]   i_pos,
    input  logic [slkt_pkg::VAL_W-1:0]   i_val,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [slkt_pkg::IDX_W-1:0]   o_index,
    output logic                         o_hit,
    output logic [slkt_pkg::VAL_W-1:0]   o_read_value,
    output logic [slkt_pkg::CNT_W-1:0]   o_cell_count,
    output logic [slkt_pkg::STAT_W-1:0]  o_status
);

    localparam int CAPACITY = slkt_pkg::CAPACITY_DEF;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int MW = (CW > slkt_pkg::POS_W) ? CW : slkt_pkg::POS_W;

    // request
    logic [slkt_pkg::OP_W-1:0]   r_op;
    logic [slkt_pkg::KEY_W-1:0]  r_key;
    logic [slkt_pkg::POS_W-1:0]  r_pos;
    logic [VALUE_BITS-1:0]       r_val;
    logic [slkt_pkg::STAT_W-1:0] r_status;
    logic [slkt_pkg::OP_W-1:0]   n_op;
    logic [slkt_pkg::KEY_W-1:0]  n_key;
    logic [slkt_pkg::POS_W-1:0]  n_pos;
    logic [VALUE_BITS-1:0]       n_val;
    logic [slkt_pkg::STAT_W-1:0] n_status;

    // search and shift
    logic [CW-1:0]         r_lo, r_hi, r_ptr, r_cnt;
    logic [CW-1:0]         n_lo, n_hi, n_ptr, n_cnt;
    logic [AW-1:0]         r_mid, n_mid;
    logic                  r_hit, n_hit;
    logic [VALUE_BITS-1:0] r_rval, n_rval;

    // result register
    logic                         r_o_valid, n_o_valid;
    logic [slkt_pkg::IDX_W-1:0]   r_o_index, n_o_index;
    logic                         r_o_hit, n_o_hit;
    logic [slkt_pkg::VAL_W-1:0]   r_o_rval, n_o_rval;
    logic [slkt_pkg::CNT_W-1:0]   r_o_cnt, n_o_cnt;
    logic [slkt_pkg::STAT_W-1:0]  r_o_status, n_o_status;

    logic [CW:0]                  bound_sum;
    logic [AW-1:0]                mid_c;
    logic [AW-1:0]                raddr;
    logic [AW-1:0]                waddr;
    logic                         we;
    logic [slkt_pkg::KEY_W-1:0]   key_wdata, key_rdata;
    logic [VALUE_BITS-1:0]        val_wdata, val_rdata;
    logic [slkt_pkg::STAT_W-1:0]  load_status;

    assign bound_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_c     = AW'(bound_sum >> 1);

    always_comb begin
        raddr = mid_c;
        if (i_cmd.shift_rd) begin
            raddr = AW'(r_ptr - CW'(1));
        end
    end

    always_comb begin
        we        = i_cmd.shift_wr | i_cmd.ins_wr | i_cmd.upd_wr;
        waddr     = AW'(r_pos);
        key_wdata = r_key;
        val_wdata = r_val;
        if (i_cmd.shift_wr) begin
            waddr     = AW'(r_ptr);
            key_wdata = key_rdata;
            val_wdata = val_rdata;
        end
    end

    slkt_ram #(
        .WIDTH (slkt_pkg::KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (key_wdata),
        .i_raddr (raddr),
        .o_rdata (key_rdata)
    );

    slkt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (val_wdata),
        .i_raddr (raddr),
        .o_rdata (val_rdata)
    );

    // status decided against the count before the request
    always_comb begin
        load_status = slkt_pkg::ST_OK;
        if (i_op == slkt_pkg::OP_INSERT) begin
            if (r_cnt >= CW'(CAPACITY)) begin
                load_status = slkt_pkg::ST_FULL;
            end else if (MW'(i_pos) > MW'(r_cnt)) begin
                load_status = slkt_pkg::ST_RANGE;
            end
        end else if (i_op == slkt_pkg::OP_UPDATE) begin
            if (MW'(i_pos) >= MW'(r_cnt)) begin
                load_status = slkt_pkg::ST_RANGE;
            end
        end
    end

    always_comb begin
        n_op       = r_op;
        n_key      = r_key;
        n_pos      = r_pos;
        n_val      = r_val;
        n_status   = r_status;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_ptr      = r_ptr;
        n_cnt      = r_cnt;
        n_mid      = r_mid;
        n_hit      = r_hit;
        n_rval     = r_rval;
        n_o_valid  = r_o_valid;
        n_o_index  = r_o_index;
        n_o_hit    = r_o_hit;
        n_o_rval   = r_o_rval;
        n_o_cnt    = r_o_cnt;
        n_o_status = r_o_status;

        if (i_cmd.load) begin
            n_op     = i_op;
            n_key    = i_key;
            n_pos    = i_pos;
            n_val    = i_val[VALUE_BITS-1:0];
            n_status = load_status;
            n_lo     = '0;
            n_hi     = r_cnt;
            n_ptr    = r_cnt;
            n_hit    = 1'b0;
        end
        if (i_cmd.probe) begin
            n_mid = mid_c;
        end
        if (i_cmd.step) begin
            if (key_rdata == r_key) begin
                n_hit  = 1'b1;
                n_rval = val_rdata;
            end else if (r_key < key_rdata) begin
                n_hi = CW'(r_mid);
            end else begin
                n_lo = CW'(r_mid) + CW'(1);
            end
        end
        if (i_cmd.shift_wr) begin
            n_ptr = r_ptr - CW'(1);
        end
        if (i_cmd.ins_wr) begin
            n_cnt = r_cnt + CW'(1);
        end

        if (i_cmd.publish) begin
            n_o_valid  = 1'b1;
            n_o_index  = r_pos;
            n_o_hit    = 1'b0;
            n_o_rval   = '0;
            n_o_cnt    = slkt_pkg::CNT_W'(r_cnt);
            n_o_status = r_status;
            if (r_op == slkt_pkg::OP_FIND) begin
                n_o_hit = r_hit;
                if (r_hit) begin
                    n_o_index = slkt_pkg::IDX_W'(r_mid);
                    n_o_rval  = slkt_pkg::VAL_W'(r_rval);
                end else begin
                    n_o_index = slkt_pkg::IDX_W'(r_lo);
                end
            end
        end else if (i_out_ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_status   <= n_status;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_ptr      <= n_ptr;
        r_mid      <= n_mid;
        r_hit      <= n_hit;
        r_rval     <= n_rval;
        r_o_index  <= n_o_index;
        r_o_hit    <= n_o_hit;
        r_o_rval   <= n_o_rval;
        r_o_cnt    <= n_o_cnt;
        r_o_status <= n_o_status;
    end

    assign o_sts.is_find    = (r_op == slkt_pkg::OP_FIND);
    assign o_sts.is_insert  = (r_op == slkt_pkg::OP_INSERT);
    assign o_sts.is_update  = (r_op == slkt_pkg::OP_UPDATE);
    assign o_sts.status_ok  = (r_status == slkt_pkg::ST_OK);
    assign o_sts.lo_eq_hi   = (r_lo == r_hi);
    assign o_sts.key_eq     = (key_rdata == r_key);
    assign o_sts.ptr_gt_pos = (MW'(r_ptr) > MW'(r_pos));
    assign o_sts.out_free   = !r_o_valid || i_out_ready;

    assign o_out_valid  = r_o_valid;
    assign o_index      = r_o_index;
    assign o_hit        = r_o_hit;
    assign o_read_value = r_o_rval;
    assign o_cell_count = r_o_cnt;
    assign o_status     = r_o_status;

endmodule

// ===== hdl/sorted_leaf_key_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_leaf_key_table_unit
// One sorted leaf of key/value cells with find, insert and update requests.
// ----------------------------------------------------------------------------
// One request is worked at a time; the result sits in an output register so
// the next request is taken while it waits, and a second finished result holds
// the controller until that register frees. Keys and values live in two RAMs
// with a registered read port. Find makes at most ceil(log2(count + 1))
// binary search probes, each one RAM read and one compare. Insert moves each
// cell from the position upward by one read and one write, then writes the
// new cell. Update writes its cell directly; unused ops and refused requests
// go straight to the result.
// There is no clearing pass after reset: cells are only read below the cell
// count.
module sorted_leaf_key_table_unit #(
    parameter int VALUE_BITS = slkt_pkg::VALUE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // op, key, position, value, zero pad
    input  logic [slkt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // index, hit, read_value, cell_count, status, zero pad
    output logic [slkt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    slkt_pkg::t_cmd cmd;
    slkt_pkg::t_sts sts;

    logic [slkt_pkg::IDX_W-1:0]  out_index;
    logic                        out_hit;
    logic [slkt_pkg::VAL_W-1:0]  out_rval;
    logic [slkt_pkg::CNT_W-1:0]  out_cnt;
    logic [slkt_pkg::STAT_W-1:0] out_status;

    slkt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    slkt_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (s_axis_tdata[slkt_pkg::IN_OP_LSB +: slkt_pkg::OP_W]),
        .i_key        (s_axis_tdata[slkt_pkg::IN_KEY_LSB +: slkt_pkg::KEY_W]),
        .i_pos        (s_axis_tdata[slkt_pkg::IN_POS_LSB +: slkt_pkg::POS_W]),
        .i_val        (s_axis_tdata[slkt_pkg::IN_VAL_LSB +: slkt_pkg::VAL_W]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_index      (out_index),
        .o_hit        (out_hit),
        .o_read_value (out_rval),
        .o_cell_count (out_cnt),
        .o_status     (out_status)
    );

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[slkt_pkg::OUT_IDX_LSB +: slkt_pkg::IDX_W]   = out_index;
        m_axis_tdata[slkt_pkg::OUT_HIT_LSB]                      = out_hit;
        m_axis_tdata[slkt_pkg::OUT_VAL_LSB +: slkt_pkg::VAL_W]   = out_rval;
        m_axis_tdata[slkt_pkg::OUT_CNT_LSB +: slkt_pkg::CNT_W]   = out_cnt;
        m_axis_tdata[slkt_pkg::OUT_STAT_LSB +: slkt_pkg::STAT_W] = out_status;
    end

endmodule
